// File: rtl/nass_pkg.sv
// Shared types and constants for the NFA active-set stepper.
package nass_pkg;

    localparam int NUM_STATES = 16;
    localparam int NUM_CELLS  = 64;
    localparam int STATE_W    = 4;
    localparam int SYM_W      = 7;
    localparam int CELL_IDX_W = $clog2(NUM_CELLS);
    localparam int COUNT_W    = 7;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 7;
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 24;
    localparam int CMD_W      = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_FINAL_STATE      = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_TRANSITION_COUNT = 1'b1;

    typedef logic [NUM_STATES-1:0] mask_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_FEED  = 2'd2,
        CMD_RSVD  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_POST
    } state_t;

    typedef struct packed {
        logic [STATE_W-1:0] from_st;
        logic [SYM_W-1:0]   sym;
        logic [STATE_W-1:0] to_st;
    } entry_t;

    // table write going to every cell; the addressed cell captures it
    typedef struct packed {
        logic                  we;
        logic [CELL_IDX_W-1:0] idx;
        entry_t                entry;
    } load_t;

    // values held steady across the chain for one walk
    typedef struct packed {
        mask_t              cur;
        logic [SYM_W-1:0]   sym;
        logic [COUNT_W-1:0] limit;
    } bcast_t;

    // token handed from cell to cell
    typedef struct packed {
        logic  vld;
        mask_t acc;
    } link_t;

endpackage

// File: rtl/nfa_active_set_stepper_unit.sv
// Top level of the NFA active-set stepper: command decode, active mask and result register.
//
//  channel  direction  handshake          payload
//  s_       in         s_tvalid/s_tready  s_tuser = cmd; s_tdata = entry, from, symbol, to
//  m_       out        m_tvalid/m_tready  m_tdata = active_states, alive, accepting
//  cfg_     in         cfg_wr_en          cfg_addr selects register, cfg_wdata value
//
// A load, start, unused command or a feed on an empty set puts its result in the
// output register on the cycle after the transfer. A feed on a live set sends a
// token down the row of 64 transition cells, one cell per cycle: a launch register
// starts it, it passes all 64 cells, and the result is then posted to the output.
// The next transfer is taken once the unit is idle and the output register is free
// or being emptied. aresetn is synchronous and active low; it sets the active set to
// state 0 and clears both registers but leaves the transition entries as they are.
module nfa_active_set_stepper_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration writes
    input  logic                            cfg_wr_en,
    input  logic [nass_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [nass_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [5:0] entry_index, [9:6] from_state, [16:10] symbol, [20:17] to_state, rest zero
    input  logic [nass_pkg::S_DATA_W-1:0]   s_tdata,
    // [1:0] cmd
    input  logic [nass_pkg::CMD_W-1:0]      s_tuser,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [15:0] active_states, [16] alive, [17] accepting, rest zero
    output logic [nass_pkg::M_DATA_W-1:0]   m_tdata
);

    nass_pkg::state_t                 state_reg, state_next;
    nass_pkg::mask_t                  mask_reg, mask_next;
    logic [nass_pkg::SYM_W-1:0]       sym_reg, sym_next;
    logic [nass_pkg::STATE_W-1:0]     final_reg;
    logic [nass_pkg::COUNT_W-1:0]     count_reg;
    logic                             inject_reg, inject_next;
    logic                             m_valid_reg, m_valid_next;
    logic [nass_pkg::M_DATA_W-1:0]    m_data_reg, m_data_next;

    logic                             out_free;
    logic                             in_xfer;
    logic                             feed_live;
    nass_pkg::cmd_t                   cmd;
    nass_pkg::entry_t                 in_entry;
    logic [nass_pkg::CELL_IDX_W-1:0]  in_idx;
    nass_pkg::load_t                  load;
    nass_pkg::bcast_t                 bcast;
    nass_pkg::link_t                  head;
    nass_pkg::link_t                  tail;
    logic [nass_pkg::COUNT_W-1:0]     limit;

    // Build a result word from a mask.
    function automatic logic [nass_pkg::M_DATA_W-1:0] pack_result(
        input nass_pkg::mask_t            m,
        input logic [nass_pkg::STATE_W-1:0] fin
    );
        logic [nass_pkg::M_DATA_W-1:0] w;
        w = '0;
        w[nass_pkg::NUM_STATES-1:0] = m;
        w[nass_pkg::NUM_STATES]     = |m;
        w[nass_pkg::NUM_STATES+1]   = m[fin];
        return w;
    endfunction

    // Unpack the input transfer.
    assign cmd              = nass_pkg::cmd_t'(s_tuser);
    assign in_idx           = s_tdata[5:0];
    assign in_entry.from_st = s_tdata[9:6];
    assign in_entry.sym     = s_tdata[16:10];
    assign in_entry.to_st   = s_tdata[20:17];

    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == nass_pkg::ST_IDLE) && out_free;
    assign in_xfer   = s_tvalid && s_tready;
    assign feed_live = (cmd == nass_pkg::CMD_FEED) && (mask_reg != '0);

    // Clamp the entry count to the size of the row.
    assign limit = (count_reg > nass_pkg::COUNT_W'(nass_pkg::NUM_CELLS))
                   ? nass_pkg::COUNT_W'(nass_pkg::NUM_CELLS) : count_reg;

    assign load.we    = in_xfer && (cmd == nass_pkg::CMD_LOAD);
    assign load.idx   = in_idx;
    assign load.entry = in_entry;

    // mask_reg and sym_reg hold still for the whole walk
    assign bcast.cur   = mask_reg;
    assign bcast.sym   = sym_reg;
    assign bcast.limit = limit;

    assign head.vld = inject_reg;
    assign head.acc = '0;

    nass_chain u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load_i  (load),
        .bcast_i (bcast),
        .head_i  (head),
        .tail_o  (tail)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            nass_pkg::ST_IDLE: begin
                if (in_xfer && feed_live) begin
                    state_next = nass_pkg::ST_WALK;
                end
            end
            nass_pkg::ST_WALK: begin
                if (tail.vld) begin
                    state_next = nass_pkg::ST_POST;
                end
            end
            nass_pkg::ST_POST: begin
                if (out_free) begin
                    state_next = nass_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = nass_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and output register updates.
    always_comb begin
        mask_next    = mask_reg;
        sym_next     = sym_reg;
        inject_next  = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        unique case (state_reg)
            nass_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    unique case (cmd)
                        nass_pkg::CMD_START: mask_next = nass_pkg::mask_t'(1);
                        nass_pkg::CMD_FEED: begin
                            // an empty set stays empty: answer at once
                            if (feed_live) begin
                                inject_next = 1'b1;
                                sym_next    = in_entry.sym;
                            end
                        end
                        nass_pkg::CMD_LOAD,
                        nass_pkg::CMD_RSVD: mask_next = mask_reg;
                        default: mask_next = mask_reg;
                    endcase
                    if (!feed_live) begin
                        m_valid_next = 1'b1;
                        m_data_next  = pack_result(mask_next, final_reg);
                    end
                end
            end
            nass_pkg::ST_WALK: begin
                if (tail.vld) begin
                    mask_next = tail.acc;
                end
            end
            nass_pkg::ST_POST: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = pack_result(mask_reg, final_reg);
                end
            end
            default: begin
                mask_next = mask_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= nass_pkg::ST_IDLE;
            mask_reg    <= nass_pkg::mask_t'(1);
            inject_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            final_reg   <= '0;
            count_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            mask_reg    <= mask_next;
            inject_reg  <= inject_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    nass_pkg::REG_FINAL_STATE:
                        final_reg <= cfg_wdata[nass_pkg::STATE_W-1:0];
                    nass_pkg::REG_TRANSITION_COUNT:
                        count_reg <= cfg_wdata[nass_pkg::COUNT_W-1:0];
                    default: count_reg <= count_reg;
                endcase
            end
        end
        sym_reg    <= sym_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// File: rtl/nass_cell.sv
// One transition cell: holds a table entry and ORs its target into the passing token.
module nass_cell (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [nass_pkg::CELL_IDX_W-1:0] cell_idx,
    input  nass_pkg::load_t                 load_i,
    input  nass_pkg::bcast_t                bcast_i,
    input  nass_pkg::link_t                 link_i,
    output nass_pkg::link_t                 link_o
);

    nass_pkg::entry_t entry_reg;
    nass_pkg::link_t  link_reg;
    nass_pkg::link_t  link_next;
    logic             in_use;
    logic             hit;

    assign in_use = {1'b0, cell_idx} < bcast_i.limit;
    assign hit    = in_use && bcast_i.cur[entry_reg.from_st]
                    && (entry_reg.sym == bcast_i.sym);

    always_comb begin
        link_next.vld = link_i.vld;
        link_next.acc = link_i.acc;
        if (hit) begin
            link_next.acc = link_i.acc | (nass_pkg::mask_t'(1) << entry_reg.to_st);
        end
    end

    always_ff @(posedge aclk) begin
        if (load_i.we && load_i.idx == cell_idx) begin
            entry_reg <= load_i.entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_reg.vld <= 1'b0;
        end else begin
            link_reg.vld <= link_next.vld;
        end
        link_reg.acc <= link_next.acc;
    end

    assign link_o = link_reg;

endmodule

// File: rtl/nass_chain.sv
// Row of transition cells; the token enters at cell 0 and leaves after the last cell.
module nass_chain (
    input  logic             aclk,
    input  logic             aresetn,
    input  nass_pkg::load_t  load_i,
    input  nass_pkg::bcast_t bcast_i,
    input  nass_pkg::link_t  head_i,
    output nass_pkg::link_t  tail_o
);

    nass_pkg::link_t links [0:nass_pkg::NUM_CELLS];

    assign links[0] = head_i;

    for (genvar g = 0; g < nass_pkg::NUM_CELLS; g++) begin : g_cell
        nass_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (nass_pkg::CELL_IDX_W'(g)),
            .load_i   (load_i),
            .bcast_i  (bcast_i),
            .link_i   (links[g]),
            .link_o   (links[g+1])
        );
    end

    assign tail_o = links[nass_pkg::NUM_CELLS];

endmodule

// File: rtl/nass_checker.sv
// Port-level checks for the NFA active-set stepper, bound to the top level.
module nass_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [nass_pkg::M_DATA_W-1:0] m_tdata
);

    // a stalled result holds its valid
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result valid dropped while stalled");

    // no new transfer while an earlier result is blocked
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while result is blocked");

    // alive matches the reported set
    a_alive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[nass_pkg::NUM_STATES] ==
                      (m_tdata[nass_pkg::NUM_STATES-1:0] != '0)))
        else $error("alive flag disagrees with active set");

    // accepting needs a live set
    a_accept_alive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[nass_pkg::NUM_STATES+1] |-> m_tdata[nass_pkg::NUM_STATES])
        else $error("accepting reported on an empty set");

    // reset empties the result register
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind nfa_active_set_stepper_unit nass_checker u_nass_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/nass_step_checker.sv
// Scoreboard for the NFA active-set stepper: mirrors the active set and checks every result.
`timescale 1ns / 100ps
module nass_step_checker
    import nass_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic [CMD_W-1:0]      s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_DATA_W-1:0]   m_tdata,
    output int                    outstanding,
    output int                    mismatch_count
);

    // bit offsets of the fields in s_tdata
    localparam int FROM_LSB = CELL_IDX_W;
    localparam int SYM_LSB  = FROM_LSB + STATE_W;
    localparam int TO_LSB   = SYM_LSB + SYM_W;

    typedef struct packed {
        mask_t active;
        logic  alive;
        logic  accepting;
    } report_t;

    entry_t             trans_table [NUM_CELLS];
    mask_t              live_set;
    logic [STATE_W-1:0] accept_state;
    logic [COUNT_W-1:0] entries_used;
    report_t            pending_reports [$];
    int                 errors = 0;

    assign mismatch_count = errors;

    // one symbol step: OR the targets of every matching entry whose source is active
    function automatic mask_t step_active_set(mask_t cur, logic [SYM_W-1:0] sym);
        mask_t nxt;
        int    n;
        nxt = '0;
        n = (entries_used > COUNT_W'(NUM_CELLS)) ? NUM_CELLS : int'(entries_used);
        for (int k = 0; k < n; k++) begin
            if (cur[trans_table[k].from_st] && trans_table[k].sym == sym)
                nxt[trans_table[k].to_st] = 1'b1;
        end
        return nxt;
    endfunction

    always @(posedge aclk) begin
        report_t want;
        if (!aresetn) begin
            live_set     = mask_t'(1);
            accept_state = '0;
            entries_used = '0;
            pending_reports.delete();
        end else begin
            // retire the result first: it belongs to an item taken earlier
            if (m_tvalid && m_tready) begin
                if (pending_reports.size() == 0) begin
                    $error("unexpected result transfer: m_tdata %h", m_tdata);
                    errors++;
                end else begin
                    want = pending_reports.pop_front();
                    if (m_tdata[NUM_STATES-1:0] !== want.active) begin
                        $error("active_states: expected %h, got %h",
                               want.active, m_tdata[NUM_STATES-1:0]);
                        errors++;
                    end
                    if (m_tdata[NUM_STATES] !== want.alive) begin
                        $error("alive: expected %b, got %b", want.alive, m_tdata[NUM_STATES]);
                        errors++;
                    end
                    if (m_tdata[NUM_STATES+1] !== want.accepting) begin
                        $error("accepting: expected %b, got %b",
                               want.accepting, m_tdata[NUM_STATES+1]);
                        errors++;
                    end
                    if (m_tdata[M_DATA_W-1:NUM_STATES+2] !== '0) begin
                        $error("padding: expected 0, got %h", m_tdata[M_DATA_W-1:NUM_STATES+2]);
                        errors++;
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_FINAL_STATE:      accept_state = cfg_wdata[STATE_W-1:0];
                    REG_TRANSITION_COUNT: entries_used = cfg_wdata[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                case (cmd_t'(s_tuser))
                    CMD_LOAD: begin
                        trans_table[s_tdata[CELL_IDX_W-1:0]] = '{
                            from_st: s_tdata[FROM_LSB +: STATE_W],
                            sym:     s_tdata[SYM_LSB +: SYM_W],
                            to_st:   s_tdata[TO_LSB +: STATE_W]};
                    end
                    CMD_START: live_set = mask_t'(1);
                    CMD_FEED: begin
                        // an empty set stays empty until the next start
                        if (live_set != '0)
                            live_set = step_active_set(live_set, s_tdata[SYM_LSB +: SYM_W]);
                    end
                    default: ;
                endcase
                want.active    = live_set;
                want.alive     = |live_set;
                want.accepting = live_set[accept_state];
                pending_reports.push_back(want);
            end
        end
        outstanding <= pending_reports.size();
    end

endmodule

// File: tb/nfa_active_set_stepper_unit_tb.sv
// Testbench top for the NFA active-set stepper: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module nfa_active_set_stepper_unit_tb;
    import nass_pkg::*;

    localparam int RANDOM_ITEMS  = 1850;
    localparam int QUIET_ITEMS   = 150;      // tail of the random part run without idling
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 80;       // longer than the walk of a feed

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic [CMD_W-1:0]      s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    int               outstanding;
    int               mismatch_count;
    logic             quiet        = 1'b0;  // high: no idling on either side
    int               gap_pct      = 0;     // chance in percent of a sender gap before a transfer
    int               ready_left   = 0;
    int               cycles       = 0;
    int               items_sent   = 0;
    int               random_base  = 0;
    bit               loaded [NUM_CELLS];   // table slots written so far
    logic [SYM_W-1:0] word_alphabet [4];    // symbols the current automaton is built over

    always #2 aclk = ~aclk;

    nfa_active_set_stepper_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    nass_step_checker u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .outstanding    (outstanding),
        .mismatch_count (mismatch_count)
    );

    // Result side: alternate stall bursts with ready stretches;
    // a stall is always followed by a ready stretch so bursts never merge.
    // Hold ready high for good once the quiet tail begins.
    always @(posedge aclk) begin
        if (quiet) begin
            m_tready <= 1'b1;
        end else if (ready_left == 0) begin
            if (m_tready && $urandom_range(0, 2) == 0) begin
                m_tready   <= 1'b0;
                ready_left <= $urandom_range(0, 18);
            end else begin
                m_tready   <= 1'b1;
                ready_left <= $urandom_range(1, 60);
            end
        end else begin
            ready_left <= ready_left - 1;
        end
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Drive one item and hold it until the transfer. Valid is lowered only ahead
    // of a gap or by drain, so back-to-back items keep it high without a glitch.
    task automatic send(cmd_t cmd, logic [CELL_IDX_W-1:0] idx, logic [STATE_W-1:0] from_st,
                        logic [SYM_W-1:0] sym, logic [STATE_W-1:0] to_st);
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= S_DATA_W'({to_st, sym, from_st, idx});
        if (cmd == CMD_LOAD)
            loaded[idx] = 1'b1;
        items_sent++;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Start and feed carry random bits in the fields they do not use.
    task automatic start_word();
        send(CMD_START, CELL_IDX_W'($urandom), STATE_W'($urandom), SYM_W'($urandom),
             STATE_W'($urandom));
    endtask

    task automatic feed(logic [SYM_W-1:0] sym);
        send(CMD_FEED, CELL_IDX_W'($urandom), STATE_W'($urandom), sym, STATE_W'($urandom));
    endtask

    // Mostly a symbol of the current automaton, now and then any symbol.
    function automatic logic [SYM_W-1:0] pick_sym();
        if ($urandom_range(0, 9) == 0)
            return SYM_W'($urandom_range(0, 127));
        return word_alphabet[$urandom_range(0, 3)];
    endfunction

    // Stop sending and wait until every expected result has been taken.
    // Skip one edge first so the checker's count includes the last transfer.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // Write both registers, final state then count, on consecutive edges with the enable held high.
    task automatic write_regs(logic [STATE_W-1:0] fs, logic [COUNT_W-1:0] cnt);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_FINAL_STATE;
        cfg_wdata <= CFG_DATA_W'(fs);
        @(posedge aclk);
        cfg_addr  <= REG_TRANSITION_COUNT;
        cfg_wdata <= CFG_DATA_W'(cnt);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int fs;
        int cnt;
        int n;
        int nstates;
        int nwords;
        int wlen;
        int sp;
        int ph;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed part ----
        gap_pct = 25;
        write_regs(0, 0);
        // with no entries in use, a feed empties the set and it stays empty
        start_word();
        feed(7'd0);
        feed(7'd127);
        send(CMD_RSVD, '1, '1, '1, '1);   // unused command reports the set unchanged
        start_word();
        send(CMD_RSVD, '0, '0, '0, '0);
        // small automaton on 'a' (97), 'b' (98), 0 and 127, nondeterministic on 'a' from state 0
        send(CMD_LOAD, 0, 0, 7'd97, 1);
        send(CMD_LOAD, 1, 1, 7'd98, 2);
        send(CMD_LOAD, 2, 0, 7'd97, 15);
        send(CMD_LOAD, 3, 15, 7'd127, 15);
        send(CMD_LOAD, 4, 2, 7'd0, 0);
        send(CMD_LOAD, 5, 1, 7'd98, 1);
        send(CMD_LOAD, 6, 0, 7'd0, 0);
        send(CMD_LOAD, 63, 15, 7'd127, 15);   // top slot, all fields at their maximum
        drain();
        write_regs(15, 7);
        start_word();
        feed(7'd97);    // {1,15}, accepting
        feed(7'd127);   // {15}
        feed(7'd98);    // no match: set empties
        feed(7'd97);    // empty stays empty
        start_word();
        feed(7'd97);
        feed(7'd98);    // {1,2}
        feed(7'd0);     // back to {0}
        feed(7'd0);     // self loop on state 0

        // ---- random part: build an automaton, configure, then run words over it ----
        random_base = items_sent;
        ph = 0;
        while (items_sent - random_base < RANDOM_ITEMS) begin
            n       = (ph == 0 || $urandom_range(0, 5) == 0) ? NUM_CELLS : $urandom_range(1, 16);
            nstates = $urandom_range(2, NUM_STATES);
            foreach (word_alphabet[j])
                word_alphabet[j] = SYM_W'($urandom_range(0, 127));
            gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
            for (int k = 0; k < n; k++)
                send(CMD_LOAD, CELL_IDX_W'(k), STATE_W'($urandom_range(0, nstates - 1)),
                     pick_sym(), STATE_W'($urandom_range(0, nstates - 1)));

            // never put an unwritten slot in use: the count stays within the written prefix
            drain();
            sp = 0;
            while (sp < NUM_CELLS && loaded[sp])
                sp++;
            if (ph == 0) begin
                cnt = 127;   // count beyond the table size clamps to the full table
            end else begin
                case ($urandom_range(0, 5))
                    0:       cnt = $urandom_range(0, n);
                    1:       cnt = (sp == NUM_CELLS) ? $urandom_range(NUM_CELLS, 127) : sp;
                    default: cnt = n;
                endcase
            end
            fs = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                             : $urandom_range(0, nstates - 1);
            write_regs(STATE_W'(fs), COUNT_W'(cnt));

            nwords = $urandom_range(2, 6);
            for (int w = 0; w < nwords && items_sent - random_base < RANDOM_ITEMS; w++) begin
                if (items_sent - random_base >= RANDOM_ITEMS - QUIET_ITEMS)
                    quiet <= 1'b1;
                // now and then skip the start and keep feeding the old set
                if ($urandom_range(0, 9) != 0)
                    start_word();
                wlen = $urandom_range(0, 12);
                for (int j = 0; j < wlen; j++) begin
                    case ($urandom_range(0, 19))
                        0:       send(CMD_RSVD, CELL_IDX_W'($urandom), STATE_W'($urandom),
                                      SYM_W'($urandom), STATE_W'($urandom));
                        1:       send(CMD_LOAD, CELL_IDX_W'($urandom), STATE_W'($urandom),
                                      SYM_W'($urandom), STATE_W'($urandom));
                        2:       start_word();
                        default: feed(pick_sym());
                    endcase
                end
            end
            ph++;
        end

        // ---- wrap up: collect the last results, let the block settle, give the verdict ----
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
